// ===== design/matrix3_inverse_unit_macros.svh =====
// assertion macros for the 3x3 matrix inverse unit
// used by the checker; expects clk_i and rst_ni in the including scope
`ifndef MATRIX3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3_INVERSE_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define M3I_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("m3i check failed");

// condition implies consequence in the next cycle
`define M3I_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("m3i check failed");

`endif

// ===== design/m3i_pkg.sv =====
// shared types, constants and helpers of the 3x3 matrix inverse unit
// no dependencies
package m3i_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QBITS         = 32;   // quotient bits kept before saturation
  localparam int unsigned DETW          = 97;   // signed determinant width
  localparam int unsigned DMW           = 96;   // determinant magnitude width
  localparam int unsigned DW            = 97;   // divisor width (2 * |det|)
  localparam int unsigned FRONT_LAT     = 6;    // register stages in the front end
  localparam int unsigned NLANES        = 9;

  typedef struct packed {
    logic signed [31:0] elem_00;
    logic signed [31:0] elem_01;
    logic signed [31:0] elem_02;
    logic signed [31:0] elem_10;
    logic signed [31:0] elem_11;
    logic signed [31:0] elem_12;
    logic signed [31:0] elem_20;
    logic signed [31:0] elem_21;
    logic signed [31:0] elem_22;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] inv_00;
    logic signed [31:0] inv_01;
    logic signed [31:0] inv_02;
    logic signed [31:0] inv_10;
    logic signed [31:0] inv_11;
    logic signed [31:0] inv_12;
    logic signed [31:0] inv_20;
    logic signed [31:0] inv_21;
    logic signed [31:0] inv_22;
    logic               invertible;
  } out_item_t;

  // determinant facts handed from the front end to every lane
  typedef struct packed {
    logic [DMW-1:0] dmag;
    logic           dneg;
    logic           singular;
    logic           nearone;
  } det_info_t;

  // per-lane result travelling to the merge stage
  typedef struct packed {
    logic             use_div;
    logic             sneg;
    logic             ovf;
    logic             singular;
    logic [31:0]      alt;
    logic [QBITS-1:0] quo;
  } lane_res_t;

  // adjugate entry k = r*3+c (cofactor of element c,r) is sign * (m[i0]*m[i1] - m[i2]*m[i3])
  localparam logic [3:0] CF_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd1, 4'd8, 4'd2, 4'd7},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd3, 4'd8, 4'd5, 4'd6},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd0, 4'd5, 4'd2, 4'd3},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd0, 4'd7, 4'd1, 4'd6},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };
  localparam logic CF_NEG [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // signed 32-bit result from a magnitude and sign, clamped
  function automatic logic [31:0] sat32(input logic [64:0] mag, input logic neg_in);
    logic big;
    big = (mag >= 65'h0_8000_0000);
    if (neg_in && (mag != '0)) begin
      return big ? SAT_MIN : 32'(-mag[31:0]);
    end
    return big ? SAT_MAX : mag[31:0];
  endfunction

endpackage

// ===== design/m3i_if.sv =====
// valid/ready channel interfaces for matrix items and results
// depends on m3i_pkg
interface m3i_in_if import m3i_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface m3i_out_if import m3i_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== design/matrix3_inverse_unit.sv =====
// 3x3 fixed-point matrix inverse by adjugate, nine divider lanes and a merge stage
// depends on m3i_pkg, m3i_if, m3i_front, m3i_lane
//
//  channel   dir  transfer      payload
//  in_i      in   valid&ready   elem_00 .. elem_22
//  out_o     out  valid&ready   inv_00 .. inv_22, invertible
//  apb       in   psel&penable  singular_epsilon at addresses 0-3
//
// the path runs through 6 front stages, 1 lane prep, 32 divider bit stages and
// 1 output register; one matrix per cycle is accepted while the output flows.
// the whole pipeline holds while the output register is full and not taken.
// reset clears the stage valid bits and sets singular_epsilon to 1.
module matrix3_inverse_unit import m3i_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  m3i_in_if.sink      in_i,
  m3i_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned LAT = FRONT_LAT + 1 + QBITS;

  logic               en;
  logic [15:0]        eps_q;
  logic [LAT-1:0]     vld_q;
  logic               out_valid_q;
  out_item_t          out_item_q, out_item_d;
  logic signed [31:0] m_f [9];
  logic signed [63:0] a_f [9];
  det_info_t          info_f;
  lane_res_t          res [NLANES];
  logic [31:0]        val [NLANES];

  // configuration register
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, eps_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= 16'd1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      eps_q <= pwdata[15:0];
    end
  end

  // pipeline advances unless the output register is stuck
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[LAT-2:0], in_i.valid};
      out_valid_q <= vld_q[LAT-1];
    end
  end

  m3i_front #(.FracBits(FracBits)) u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .item_i (in_i.item),
    .eps_i  (eps_q),
    .m_o    (m_f),
    .a_o    (a_f),
    .info_o (info_f)
  );

  for (genvar k = 0; k < NLANES; k++) begin : g_lane
    m3i_lane #(.FracBits(FracBits)) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .m_i    (m_f[k]),
      .a_i    (a_f[k]),
      .info_i (info_f),
      .res_o  (res[k])
    );
  end

  // merge: pick quotient or bypass value per lane and saturate
  always_comb begin
    for (int k = 0; k < NLANES; k++) begin
      val[k] = res[k].use_div ? sat32({32'd0, res[k].ovf, res[k].quo}, res[k].sneg)
                              : res[k].alt;
    end
    out_item_d.inv_00     = val[0];
    out_item_d.inv_01     = val[1];
    out_item_d.inv_02     = val[2];
    out_item_d.inv_10     = val[3];
    out_item_d.inv_11     = val[4];
    out_item_d.inv_12     = val[5];
    out_item_d.inv_20     = val[6];
    out_item_d.inv_21     = val[7];
    out_item_d.inv_22     = val[8];
    out_item_d.invertible = !res[0].singular;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

endmodule

// ===== design/m3i_front.sv =====
// front end: cofactors, determinant and singular / near-one tests
// depends on m3i_pkg
module m3i_front import m3i_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  in_item_t           item_i,
  input  logic [15:0]        eps_i,
  output logic signed [31:0] m_o [9],
  output logic signed [63:0] a_o [9],
  output det_info_t          info_o
);

  logic signed [31:0] m_in [9];
  logic signed [31:0] ma_q [9], mb_q [9], mc_q [9], md_q [9], me_q [9], mf_q [9];
  logic signed [63:0] pa_q [9][2];
  logic signed [63:0] ab_q [9], ac_q [9], ad_q [9], ae_q [9], af_q [9];
  logic signed [63:0] phc_q [3];
  logic signed [64:0] plc_q [3];
  logic signed [DETW-1:0] det_d, det_q;
  logic [DMW-1:0]       dmag_e, dmag_q;
  logic                 dneg_q;
  logic signed [DETW:0] one_sh, dd_e, dd_q;
  logic [DETW-1:0]      ddmag;
  logic [DMW-1:0]       epsw;
  det_info_t            info_d, info_q;

  assign m_in[0] = item_i.elem_00;
  assign m_in[1] = item_i.elem_01;
  assign m_in[2] = item_i.elem_02;
  assign m_in[3] = item_i.elem_10;
  assign m_in[4] = item_i.elem_11;
  assign m_in[5] = item_i.elem_12;
  assign m_in[6] = item_i.elem_20;
  assign m_in[7] = item_i.elem_21;
  assign m_in[8] = item_i.elem_22;

  // stage a: the eighteen 32x32 products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        ma_q[k]    <= m_in[k];
        pa_q[k][0] <= 64'(m_in[CF_IDX[k][0]]) * 64'(m_in[CF_IDX[k][1]]);
        pa_q[k][1] <= 64'(m_in[CF_IDX[k][2]]) * 64'(m_in[CF_IDX[k][3]]);
      end
    end
  end

  // stage b: signed cofactors, wrapping at 64 bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        mb_q[k] <= ma_q[k];
        ab_q[k] <= CF_NEG[k] ? 64'(pa_q[k][1] - pa_q[k][0]) : 64'(pa_q[k][0] - pa_q[k][1]);
      end
    end
  end

  // stage c: row 0 times its cofactors (first adjugate column), split in 32-bit halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        mc_q[k] <= mb_q[k];
        ac_q[k] <= ab_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        phc_q[j] <= 64'(mb_q[j]) * 64'($signed(ab_q[3*j][63:32]));
        plc_q[j] <= 65'(mb_q[j]) * 65'($signed({1'b0, ab_q[3*j][31:0]}));
      end
    end
  end

  // stage d: determinant sum
  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + DETW'($signed({phc_q[j], 32'd0})) + DETW'(plc_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        md_q[k] <= mc_q[k];
        ad_q[k] <= ac_q[k];
      end
      det_q <= det_d;
    end
  end

  // stage e: magnitude and distance from one
  assign dmag_e = det_q[DETW-1] ? DMW'(-det_q) : DMW'(det_q);
  assign one_sh = (DETW+1)'(1) <<< (3*FracBits);
  assign dd_e   = one_sh - (DETW+1)'(det_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        me_q[k] <= md_q[k];
        ae_q[k] <= ad_q[k];
      end
      dmag_q <= dmag_e;
      dneg_q <= det_q[DETW-1];
      dd_q   <= dd_e;
    end
  end

  // stage f: threshold tests against epsilon
  assign ddmag = dd_q[DETW] ? DETW'(-dd_q) : DETW'(dd_q);
  assign epsw  = DMW'(eps_i) << (2*FracBits);

  always_comb begin
    info_d.dmag     = dmag_q;
    info_d.dneg     = dneg_q;
    info_d.singular = (dmag_q == '0) || (dmag_q < epsw);
    info_d.nearone  = (DETW'(epsw) >= ddmag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        mf_q[k] <= me_q[k];
        af_q[k] <= ae_q[k];
      end
      info_q <= info_d;
    end
  end

  assign m_o    = mf_q;
  assign a_o    = af_q;
  assign info_o = info_q;

endmodule

// ===== design/m3i_lane.sv =====
// one lane: rounding path and a pipelined restoring divider, one bit per stage
// depends on m3i_pkg
module m3i_lane import m3i_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] m_i,
  input  logic signed [63:0] a_i,
  input  det_info_t          info_i,
  output lane_res_t          res_o
);

  localparam int unsigned NW = (2*FracBits + 66 > DW + 1) ? 2*FracBits + 66 : DW + 1;

  logic [63:0]   am;
  logic          aneg;
  logic [NW-1:0] num;
  logic [DW-1:0] dvs;
  logic [64:0]   rnd, qn;
  lane_res_t     res0;

  logic [DW-1:0]  r_q  [QBITS+1];
  logic [DW-1:0]  r_d  [QBITS+1];
  logic [31:0]    nl_q [QBITS+1];
  logic [31:0]    nl_d [QBITS+1];
  logic [DW-1:0]  dv_q [QBITS+1];
  lane_res_t      rs_q [QBITS+1];
  lane_res_t      rs_d [QBITS+1];
  logic [DW:0]    t_w  [QBITS+1];
  logic           ge_w [QBITS+1];

  // prep: numerator, divisor, overflow check and non-dividing result
  assign aneg = a_i[63];
  assign am   = aneg ? 64'(-a_i) : 64'(a_i);
  assign num  = (NW'(am) << (2*FracBits + 1)) + NW'(info_i.dmag);
  assign dvs  = {info_i.dmag, 1'b0};
  assign rnd  = 65'(am) + (65'(1) << (FracBits - 1));
  assign qn   = rnd >> FracBits;

  always_comb begin
    res0.use_div  = !info_i.singular && !info_i.nearone;
    res0.sneg     = aneg ^ info_i.dneg;
    res0.ovf      = (num >> 32) >= NW'(dvs);
    res0.singular = info_i.singular;
    res0.alt      = info_i.singular ? m_i : sat32(qn, aneg);
    res0.quo      = '0;
  end

  // division steps, each takes the next numerator bit
  always_comb begin
    r_d[0]  = DW'(num >> 32);
    nl_d[0] = num[31:0];
    rs_d[0] = res0;
    t_w[0]  = '0;
    ge_w[0] = 1'b0;
    for (int j = 1; j <= QBITS; j++) begin
      t_w[j]  = {r_q[j-1], nl_q[j-1][31]};
      ge_w[j] = t_w[j] >= {1'b0, dv_q[j-1]};
      r_d[j]  = ge_w[j] ? DW'(t_w[j] - {1'b0, dv_q[j-1]}) : t_w[j][DW-1:0];
      nl_d[j] = {nl_q[j-1][30:0], 1'b0};
      rs_d[j] = rs_q[j-1];
      rs_d[j].quo = {rs_q[j-1].quo[QBITS-2:0], ge_w[j]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]  <= r_d[0];
      nl_q[0] <= nl_d[0];
      dv_q[0] <= dvs;
      rs_q[0] <= rs_d[0];
      for (int j = 1; j <= QBITS; j++) begin
        r_q[j]  <= r_d[j];
        nl_q[j] <= nl_d[j];
        dv_q[j] <= dv_q[j-1];
        rs_q[j] <= rs_d[j];
      end
    end
  end

  assign res_o = rs_q[QBITS];

endmodule

// ===== design/m3i_checker.sv =====
// port-level checks of the matrix inverse unit, bound to the top level
// depends on matrix3_inverse_unit_macros.svh and m3i_pkg
`include "matrix3_inverse_unit_macros.svh"

module m3i_checker import m3i_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input out_item_t   out_item_i,
  input logic        psel_i,
  input logic        penable_i,
  input logic        pwrite_i,
  input logic [2:0]  paddr_i,
  input logic [31:0] pwdata_i,
  input logic [31:0] prdata_i
);

  logic cfg_wr;

  // write transfer to the epsilon register
  assign cfg_wr = psel_i && penable_i && pwrite_i && !paddr_i[2];

  // a stalled result stays offered
  `M3I_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // a stalled result keeps its value
  `M3I_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_item_i))
  // input is only held off by a waiting result
  `M3I_ASSERT_NOW(a_in_stall, !in_ready_i, out_valid_i && !out_ready_i)
  // register write reads back
  `M3I_ASSERT_NEXT(a_cfg_rb, cfg_wr, paddr_i[2] || (prdata_i == {16'd0, $past(pwdata_i[15:0])}))

endmodule

bind matrix3_inverse_unit m3i_checker u_m3i_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.item),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);
